// File: rtl/core/cpc_pkg.sv
// Shared constants and interface structs for the Chen prime classifier.
package cpc_pkg;

    localparam int VALUE_BITS = 16;
    localparam int LIMIT_W    = 16;
    localparam int COUNT_W    = 16;

    // Numbers under test reach candidate + 2, so one bit more than a candidate.
    localparam int NUM_W = VALUE_BITS + 1;
    // Trial divisors never pass the square root of the number plus a small step.
    localparam int DIV_W = (NUM_W + 1) / 2 + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int CMP_W = (NUM_W > LIMIT_W) ? NUM_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = {LIMIT_W{1'b1}};
    localparam logic [COUNT_W-1:0]    COUNT_MAX      = {COUNT_W{1'b1}};
    localparam logic [VALUE_BITS-1:0] MIN_PRIME      = VALUE_BITS'(2);
    localparam logic [NUM_W-1:0]      PAIR_OFFSET    = NUM_W'(2);
    localparam logic [DIV_W-1:0]      FIRST_DIVISOR  = DIV_W'(2);
    localparam logic [DIV_W-1:0]      SECOND_DIVISOR = DIV_W'(3);
    localparam logic [DIV_W-1:0]      DIVISOR_STEP   = DIV_W'(2);

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_res_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] n;
    } fac_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             found;
        logic [NUM_W-1:0] cofactor;
    } fac_res_t;

endpackage

// File: rtl/core/cpc_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module cpc_divider
    import cpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             q_bit;
    logic [DIV_W-1:0] rem_next;

    // The quotient register starts with the dividend; its top bit feeds the
    // partial remainder while quotient bits shift in at the bottom.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        q_bit    = ~diff[DIV_W];
        rem_next = q_bit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

    a_busy_counts: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with an exhausted bit counter");

endmodule

// File: rtl/core/cpc_factor.sv
// Smallest-factor search by trial division on the shared divider.
module cpc_factor
    import cpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fac_req_t req,
    output fac_res_t res
);

    typedef enum logic {
        F_IDLE,
        F_WAIT
    } fac_state_t;

    fac_state_t       state_reg;
    logic [NUM_W-1:0] n_reg;
    logic [DIV_W-1:0] d_reg;
    logic             div_start_reg;
    logic             done_reg;
    logic             found_reg;
    logic [NUM_W-1:0] cofactor_reg;

    div_req_t         div_req;
    div_res_t         div_res;
    logic             past_root;
    logic [DIV_W-1:0] d_next;

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = n_reg;
    assign div_req.divisor  = d_reg;

    cpc_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    // d * d > n exactly when floor(n / d) < d, so the quotient ends the search.
    always_comb
    begin
        past_root = div_res.quotient < NUM_W'(d_reg);
        d_next    = (d_reg == FIRST_DIVISOR) ? SECOND_DIVISOR : d_reg + DIVISOR_STEP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            div_start_reg <= 1'b0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            done_reg      <= 1'b0;
            unique case (state_reg)
                F_IDLE:
                begin
                    if (req.start)
                    begin
                        n_reg         <= req.n;
                        d_reg         <= FIRST_DIVISOR;
                        div_start_reg <= 1'b1;
                        state_reg     <= F_WAIT;
                    end
                end
                F_WAIT:
                begin
                    if (div_res.done)
                    begin
                        priority if (past_root)
                        begin
                            found_reg <= 1'b0;
                            done_reg  <= 1'b1;
                            state_reg <= F_IDLE;
                        end
                        else if (div_res.remainder == '0)
                        begin
                            found_reg    <= 1'b1;
                            cofactor_reg <= div_res.quotient;
                            done_reg     <= 1'b1;
                            state_reg    <= F_IDLE;
                        end
                        else
                        begin
                            d_reg         <= d_next;
                            div_start_reg <= 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign res.busy     = (state_reg != F_IDLE);
    assign res.done     = done_reg;
    assign res.found    = found_reg;
    assign res.cofactor = cofactor_reg;

endmodule

// File: rtl/core/chen_prime_classifier.sv
// Chen prime classifier top level: item handshake, test sequencing and Chen count.
//
//  channel   direction  handshake                 payload
//  input     in         in_valid / in_ready       candidate, restart
//  result    out        out_valid / out_ready     is_prime, is_chen, chen_total
//  config    in         upper_limit_we            upper_limit
//
// Each trial divisor costs one full division on the one shared divider.
// An item runs up to three searches (candidate, candidate + 2, and its
// cofactor), and each costs a division for every divisor tried in it;
// divisors are 2 and the odd numbers up to the square root, so primes near the
// limit take longest.
// in_ready is high only between items; a finished result waits in the output
// register and the next item is taken while it stalls.
// Reset clears the Chen count and sets upper_limit to all ones.
module chen_prime_classifier
    import cpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] candidate,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_prime,
    output logic                  is_chen,
    output logic [COUNT_W-1:0]    chen_total,
    input  logic                  upper_limit_we,
    input  logic [LIMIT_W-1:0]    upper_limit
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST_CAND,
        ST_TEST_PAIR,
        ST_TEST_COFACTOR,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [VALUE_BITS-1:0] cand_reg;
    logic                  prime_reg;
    logic                  chen_reg;
    logic                  fac_start_reg;
    logic [NUM_W-1:0]      fac_n_reg;
    logic                  out_valid_reg;
    logic                  is_prime_reg;
    logic                  is_chen_reg;
    logic [COUNT_W-1:0]    chen_total_reg;

    fac_req_t              fac_req;
    fac_res_t              fac_res;
    logic                  in_xfer;
    logic                  in_range;
    logic                  out_free;
    logic [COUNT_W-1:0]    count_next;

    assign fac_req.start = fac_start_reg;
    assign fac_req.n     = fac_n_reg;

    cpc_factor u_factor (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fac_req),
        .res   (fac_res)
    );

    always_comb
    begin
        in_xfer    = in_valid && in_ready;
        in_range   = (candidate >= MIN_PRIME) && (CMP_W'(candidate) < CMP_W'(limit_reg));
        out_free   = !out_valid_reg || out_ready;
        count_next = (chen_reg && (count_reg != COUNT_MAX)) ? count_reg + COUNT_W'(1)
                                                             : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (upper_limit_we)
        begin
            limit_reg <= upper_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            fac_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            prime_reg     <= 1'b0;
            chen_reg      <= 1'b0;
        end
        else
        begin
            fac_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        cand_reg  <= candidate;
                        prime_reg <= 1'b0;
                        chen_reg  <= 1'b0;
                        if (restart)
                        begin
                            count_reg <= '0;
                        end
                        if (in_range)
                        begin
                            fac_n_reg     <= NUM_W'(candidate);
                            fac_start_reg <= 1'b1;
                            state_reg     <= ST_TEST_CAND;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_TEST_CAND:
                begin
                    if (fac_res.done)
                    begin
                        if (fac_res.found)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            prime_reg     <= 1'b1;
                            fac_n_reg     <= NUM_W'(cand_reg) + PAIR_OFFSET;
                            fac_start_reg <= 1'b1;
                            state_reg     <= ST_TEST_PAIR;
                        end
                    end
                end
                ST_TEST_PAIR:
                begin
                    if (fac_res.done)
                    begin
                        if (fac_res.found)
                        begin
                            // Composite partner: Chen only if the cofactor is prime.
                            fac_n_reg     <= fac_res.cofactor;
                            fac_start_reg <= 1'b1;
                            state_reg     <= ST_TEST_COFACTOR;
                        end
                        else
                        begin
                            chen_reg  <= 1'b1;
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_TEST_COFACTOR:
                begin
                    if (fac_res.done)
                    begin
                        chen_reg  <= !fac_res.found;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        count_reg      <= count_next;
                        out_valid_reg  <= 1'b1;
                        is_prime_reg   <= prime_reg;
                        is_chen_reg    <= chen_reg;
                        chen_total_reg <= count_next;
                        state_reg      <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign is_prime   = is_prime_reg;
    assign is_chen    = is_chen_reg;
    assign chen_total = chen_total_reg;

    a_chen_is_prime: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_chen |-> is_prime)
        else $error("Chen result without a prime result");

    a_chen_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_chen |-> chen_total != '0)
        else $error("Chen result with an empty count");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer taken while an item is in work");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !fac_res.busy && !fac_res.done)
        else $error("factor search active with no item in work");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the Chen prime classifier: directed and random tests.
module tb_top
    import cpc_pkg::*;
();

    localparam int STALL_LIMIT   = 60000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int IDLE_PERCENT  = 13;

    typedef struct {
        logic               is_prime;
        logic               is_chen;
        logic [COUNT_W-1:0] total;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [VALUE_BITS-1:0] candidate = '0;
    logic                  restart = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  is_prime;
    logic                  is_chen;
    logic [COUNT_W-1:0]    chen_total;
    logic                  upper_limit_we = 1'b0;
    logic [LIMIT_W-1:0]    upper_limit = LIMIT_RESET;

    // Predictor state, mirrors the block's register and Chen count.
    logic [LIMIT_W-1:0] limit_model = LIMIT_RESET;
    logic [COUNT_W-1:0] chen_tally = '0;

    verdict_t pending_verdicts[$];
    verdict_t head_verdict;
    bit       no_idle = 1'b0;
    int       errors = 0;
    int       items_sent = 0;
    int       chen_seen = 0;
    int       limit_writes = 0;
    int       quiet_cycles = 0;

    chen_prime_classifier i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .candidate      (candidate),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .is_prime       (is_prime),
        .is_chen        (is_chen),
        .chen_total     (chen_total),
        .upper_limit_we (upper_limit_we),
        .upper_limit    (upper_limit)
    );

    always #1 clk = ~clk;

    function automatic logic [VALUE_BITS:0] least_factor(input logic [VALUE_BITS:0] n);
        int unsigned d;
        for (d = 2; d * d <= n; d++)
        begin
            if (n % d == 0)
                return d[VALUE_BITS:0];
        end
        return n;
    endfunction

    function automatic bit prime_check(input logic [VALUE_BITS:0] n);
        if (n < 2)
            return 1'b0;
        return least_factor(n) == n;
    endfunction

    // True when q is prime or a product of exactly two primes.
    function automatic bit prime_or_semiprime(input logic [VALUE_BITS:0] q);
        logic [VALUE_BITS:0] f;
        if (q < 2)
            return 1'b0;
        f = least_factor(q);
        if (f == q)
            return 1'b1;
        return prime_check(q / f);
    endfunction

    function automatic verdict_t classify(input logic [VALUE_BITS-1:0] c, input logic r);
        verdict_t            v;
        logic [VALUE_BITS:0] wide;
        wide = {1'b0, c};
        v.is_prime = 1'b0;
        v.is_chen  = 1'b0;
        if (r)
            chen_tally = '0;
        if (c >= 2 && c < limit_model)
        begin
            v.is_prime = prime_check(wide);
            if (v.is_prime)
                v.is_chen = prime_or_semiprime(wide + (VALUE_BITS + 1)'(2));
        end
        if (v.is_chen && chen_tally != COUNT_MAX)
            chen_tally = chen_tally + 1'b1;
        v.total = chen_tally;
        return v;
    endfunction

    // Mostly small values keep trial division short; a share spans all 16 bits.
    function automatic logic [VALUE_BITS-1:0] pick_candidate();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return VALUE_BITS'($urandom_range(2047));
        else if (roll < 88)
            return VALUE_BITS'($urandom_range(65535));
        else
            return VALUE_BITS'(int'(limit_model) + $urandom_range(4) - 2);
    endfunction

    task automatic send_item(input logic [VALUE_BITS-1:0] c, input logic r);
        if (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PERCENT)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= c;
        restart   <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_verdicts.push_back(classify(c, r));
        items_sent++;
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_all_results();
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        drop_valid();
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        upper_limit_we <= 1'b1;
        upper_limit    <= v;
        @(posedge clk);
        upper_limit_we <= 1'b0;
        limit_model = v;
        limit_writes++;
    endtask

    task automatic test_small_and_edge_values();
        send_item(VALUE_BITS'(0), 1'b0);
        send_item(VALUE_BITS'(1), 1'b0);
        send_item(VALUE_BITS'(2), 1'b0);
        send_item(VALUE_BITS'(3), 1'b0);
        send_item(VALUE_BITS'(4), 1'b0);
        send_item(VALUE_BITS'(7), 1'b0);
        send_item(VALUE_BITS'(23), 1'b0);
        send_item(VALUE_BITS'(43), 1'b0);
        send_item(VALUE_BITS'(65534), 1'b0);
        send_item(VALUE_BITS'(65535), 1'b0);
        drop_valid();
    endtask

    task automatic test_limit_extremes();
        // A limit of zero rejects everything, including the smallest prime.
        set_limit('0);
        send_item(VALUE_BITS'(0), 1'b0);
        send_item(VALUE_BITS'(2), 1'b0);
        send_item(VALUE_BITS'(65535), 1'b0);
        set_limit(LIMIT_W'(3));
        send_item(VALUE_BITS'(2), 1'b0);
        send_item(VALUE_BITS'(3), 1'b0);
        set_limit(LIMIT_W'(14));
        send_item(VALUE_BITS'(13), 1'b0);
        send_item(VALUE_BITS'(14), 1'b0);
        set_limit(LIMIT_RESET);
        send_item(VALUE_BITS'(65521), 1'b0);
        drop_valid();
    endtask

    task automatic test_restart_cases();
        send_item(VALUE_BITS'(5), 1'b0);
        send_item(VALUE_BITS'(0), 1'b1);
        send_item(VALUE_BITS'(65535), 1'b1);
        send_item(VALUE_BITS'(13), 1'b1);
        drop_valid();
    endtask

    task automatic test_chen_run();
        int n;
        set_limit(LIMIT_RESET);
        // Every small value back to back with no idling, counted from a restart.
        no_idle = 1'b1;
        send_item(VALUE_BITS'(2), 1'b1);
        for (n = 0; n < 40; n++)
            send_item(VALUE_BITS'(n), 1'b0);
        send_item(VALUE_BITS'(2), 1'b1);
        no_idle = 1'b0;
        drop_valid();
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        int roll;
        for (phase = 0; phase < 8; phase++)
        begin
            roll = $urandom_range(2);
            if (phase == 0)
                set_limit(LIMIT_RESET);
            else if (roll == 0)
                set_limit(LIMIT_W'($urandom_range(65535)));
            else if (roll == 1)
                set_limit(LIMIT_W'($urandom_range(4096)));
            else
                set_limit(LIMIT_RESET);
            no_idle = (phase == 3);
            for (n = 0; n < 58; n++)
            begin
                // Hold the sender off until the block has drained completely.
                if (phase == 5 && n == 30)
                begin
                    drop_valid();
                    wait_all_results();
                end
                send_item(pick_candidate(), $urandom_range(99) < 4);
            end
            no_idle = 1'b0;
        end
        drop_valid();
    endtask

    always @(posedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result transfer with no expected result pending");
                errors++;
            end
            else
            begin
                head_verdict = pending_verdicts.pop_front();
                if (is_chen)
                    chen_seen++;
                if (is_prime !== head_verdict.is_prime)
                begin
                    $error("is_prime: expected %0b, got %0b", head_verdict.is_prime, is_prime);
                    errors++;
                end
                if (is_chen !== head_verdict.is_chen)
                begin
                    $error("is_chen: expected %0b, got %0b", head_verdict.is_chen, is_chen);
                    errors++;
                end
                if (chen_total !== head_verdict.total)
                begin
                    $error("chen_total: expected %0d, got %0d", head_verdict.total, chen_total);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[chen_prime_classifier] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_small_and_edge_values();
        test_limit_extremes();
        test_restart_cases();
        test_chen_run();
        test_random_traffic();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_verdicts.size());
            errors++;
        end
        $display("Classified %0d candidates (%0d Chen primes reported) over %0d limit settings,",
                 items_sent, chen_seen, limit_writes);
        $display("including limit extremes, restarts on rejected values and a gapless run.");
        if (errors == 0)
            $display("[chen_prime_classifier] OK");
        else
            $display("[chen_prime_classifier] ERROR");
        $finish;
    end

endmodule

// File: chen_prime_classifier.f
rtl/core/cpc_pkg.sv
rtl/core/cpc_divider.sv
rtl/core/cpc_factor.sv
rtl/core/chen_prime_classifier.sv
tb/tb_top.sv
